### rtl/asoc_pkg.sv
package asoc_pkg;

   localparam int TIME_BITS_DEFAULT  = 32;
   localparam int RISK_BITS_DEFAULT  = 16;
   localparam int COUNT_BITS_DEFAULT = 32;

   localparam longint unsigned RISK_THRESHOLD_RESET = 64'd32768;

   typedef logic [1:0] reg_index_type;

   localparam reg_index_type REG_RISK_THRESHOLD  = 2'd0;
   localparam reg_index_type REG_SNOOZE_TICKS    = 2'd1;
   localparam reg_index_type REG_DETECTION_TICKS = 2'd2;

endpackage

### rtl/alert_snooze_outcome_counter_top.sv
// Scores alert streams one sample per beat: each sample is checked against the
// risk threshold and the snooze boundary, classified as a hit or a false alert,
// and the trajectory is scored into episode counters on its last sample. The
// block sustains one sample per cycle while result beats are taken. A sample
// is held in the input register, then the scoring stage loads the result
// register and the trajectory and counter state in the same edge. While a
// result beat is held off, the input register keeps its sample and the input
// stalls once that register is full. The six counters saturate and are shown
// on every result beat as they stand after that sample. The user must write
// registers through the csr_ port only while no sample is in flight; the block
// does not enforce this. first_of_run clears all counters.
module alert_snooze_outcome_counter_top #(
   parameter  int TIME_BITS     = asoc_pkg::TIME_BITS_DEFAULT,
   parameter  int RISK_BITS     = asoc_pkg::RISK_BITS_DEFAULT,
   parameter  int COUNT_BITS    = asoc_pkg::COUNT_BITS_DEFAULT,
   localparam int CSR_DATA_BITS = (TIME_BITS > 32) ? 64 : 32,
   localparam int CSR_ADDR_BITS = (TIME_BITS > 32) ? 5 : 4
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [TIME_BITS-1:0]     req_sample_time,
   input  logic [RISK_BITS-1:0]     req_risk,
   input  logic                     req_has_event,
   input  logic [TIME_BITS-1:0]     req_event_tick,
   input  logic                     req_first_of_trajectory,
   input  logic                     req_last_of_trajectory,
   input  logic                     req_first_of_run,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_alert,
   output logic                     rsp_alert_is_hit,
   output logic [COUNT_BITS-1:0]    rsp_episode_tp_count,
   output logic [COUNT_BITS-1:0]    rsp_episode_fn_count,
   output logic [COUNT_BITS-1:0]    rsp_episode_fp_count,
   output logic [COUNT_BITS-1:0]    rsp_episode_tn_count,
   output logic [COUNT_BITS-1:0]    rsp_prediction_tp_count,
   output logic [COUNT_BITS-1:0]    rsp_prediction_fp_count,

   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);
   import asoc_pkg::*;

   localparam int EP_TP = 0;
   localparam int EP_FN = 1;
   localparam int EP_FP = 2;
   localparam int EP_TN = 3;
   localparam int PR_TP = 4;
   localparam int PR_FP = 5;
   localparam int NUM_COUNTERS = 6;

   logic [RISK_BITS-1:0] risk_threshold;
   logic [TIME_BITS-1:0] snooze_ticks;
   logic [TIME_BITS-1:0] detection_ticks;

   asoc_csr #(
      .TIME_BITS (TIME_BITS),
      .RISK_BITS (RISK_BITS),
      .DATA_BITS (CSR_DATA_BITS),
      .ADDR_BITS (CSR_ADDR_BITS)
   ) u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (csr_psel),
      .penable         (csr_penable),
      .pwrite          (csr_pwrite),
      .paddr           (csr_paddr),
      .pwdata          (csr_pwdata),
      .prdata          (csr_prdata),
      .pready          (csr_pready),
      .risk_threshold  (risk_threshold),
      .snooze_ticks    (snooze_ticks),
      .detection_ticks (detection_ticks)
   );

   // input stage
   logic                 in_valid_ff;
   logic [TIME_BITS-1:0] time_ff;
   logic [RISK_BITS-1:0] risk_ff;
   logic                 has_event_ff;
   logic [TIME_BITS-1:0] event_ff;
   logic                 first_traj_ff;
   logic                 last_traj_ff;
   logic                 first_run_ff;

   // scoring state and result
   logic [TIME_BITS:0]    snooze_until_ff, snooze_until_in;
   logic                  alerted_ff, alerted_in;
   logic                  traj_alert_ff, traj_alert_in;
   logic                  traj_hit_ff, traj_hit_in;
   logic [COUNT_BITS-1:0] count_ff [NUM_COUNTERS];
   logic [COUNT_BITS-1:0] count_in [NUM_COUNTERS];
   logic                  out_valid_ff;
   logic                  alert_ff, alert_in;
   logic                  hit_ff, hit_in;

   logic advance;
   logic fire;
   logic alerted_eff, traj_alert_eff, traj_hit_eff;
   logic traj_alert_end, traj_hit_end;
   logic [NUM_COUNTERS-1:0] bump;
   logic [TIME_BITS:0] window_end;

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         time_ff       <= req_sample_time;
         risk_ff       <= req_risk;
         has_event_ff  <= req_has_event;
         event_ff      <= req_event_tick;
         first_traj_ff <= req_first_of_trajectory;
         last_traj_ff  <= req_last_of_trajectory;
         first_run_ff  <= req_first_of_run;
      end
   end

   assign window_end = {1'b0, time_ff} + {1'b0, detection_ticks};

   always_comb begin
      alerted_eff    = alerted_ff    && !first_traj_ff;
      traj_alert_eff = traj_alert_ff && !first_traj_ff;
      traj_hit_eff   = traj_hit_ff   && !first_traj_ff;

      alert_in = (risk_ff > risk_threshold) &&
                 (!alerted_eff || ({1'b0, time_ff} > snooze_until_ff));
      hit_in   = alert_in && has_event_ff && (time_ff < event_ff) &&
                 (window_end >= {1'b0, event_ff});

      snooze_until_in = alert_in ? ({1'b0, time_ff} + {1'b0, snooze_ticks})
                                 : snooze_until_ff;

      traj_alert_end = traj_alert_eff || alert_in;
      traj_hit_end   = traj_hit_eff || hit_in;

      bump        = '0;
      bump[PR_TP] = alert_in && hit_in;
      bump[PR_FP] = alert_in && !hit_in;
      bump[EP_TP] = last_traj_ff && has_event_ff && traj_hit_end;
      bump[EP_FN] = last_traj_ff && has_event_ff && !traj_hit_end;
      bump[EP_FP] = last_traj_ff && !has_event_ff && traj_alert_end;
      bump[EP_TN] = last_traj_ff && !has_event_ff && !traj_alert_end;

      alerted_in    = !last_traj_ff && (alerted_eff || alert_in);
      traj_alert_in = !last_traj_ff && traj_alert_end;
      traj_hit_in   = !last_traj_ff && traj_hit_end;

      for (int k = 0; k < NUM_COUNTERS; k++) begin
         count_in[k] = first_run_ff ? '0 : count_ff[k];
         if (bump[k] && (count_in[k] != '1)) begin
            count_in[k] = count_in[k] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff    <= 1'b0;
         snooze_until_ff <= '0;
         alerted_ff      <= 1'b0;
         traj_alert_ff   <= 1'b0;
         traj_hit_ff     <= 1'b0;
         for (int k = 0; k < NUM_COUNTERS; k++) begin
            count_ff[k] <= '0;
         end
      end else begin
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            snooze_until_ff <= snooze_until_in;
            alerted_ff      <= alerted_in;
            traj_alert_ff   <= traj_alert_in;
            traj_hit_ff     <= traj_hit_in;
            for (int k = 0; k < NUM_COUNTERS; k++) begin
               count_ff[k] <= count_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         alert_ff <= alert_in;
         hit_ff   <= hit_in;
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_alert               = alert_ff;
   assign rsp_alert_is_hit        = hit_ff;
   assign rsp_episode_tp_count    = count_ff[EP_TP];
   assign rsp_episode_fn_count    = count_ff[EP_FN];
   assign rsp_episode_fp_count    = count_ff[EP_FP];
   assign rsp_episode_tn_count    = count_ff[EP_TN];
   assign rsp_prediction_tp_count = count_ff[PR_TP];
   assign rsp_prediction_fp_count = count_ff[PR_FP];

`ifndef SYNTHESIS
   a_hit_needs_alert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alert || !rsp_alert_is_hit))
      else $error("hit reported without alert");

   a_snooze_held: assert property (@(posedge clock) disable iff (reset)
      (fire && !alert_in) |=> $stable(snooze_until_ff))
      else $error("snooze boundary moved without alert");

   a_pred_monotonic: assert property (@(posedge clock) disable iff (reset)
      (fire && !first_run_ff) |=>
         (count_ff[PR_TP] >= $past(count_ff[PR_TP])) &&
         (count_ff[PR_FP] >= $past(count_ff[PR_FP])))
      else $error("prediction counter decreased");

   a_one_episode: assert property (@(posedge clock) disable iff (reset)
      fire |-> $onehot0(bump[EP_TN:EP_TP]))
      else $error("more than one episode outcome per sample");
`endif

endmodule

### rtl/asoc_csr.sv
module asoc_csr #(
   parameter int TIME_BITS = asoc_pkg::TIME_BITS_DEFAULT,
   parameter int RISK_BITS = asoc_pkg::RISK_BITS_DEFAULT,
   parameter int DATA_BITS = 32,
   parameter int ADDR_BITS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready,
   output logic [RISK_BITS-1:0] risk_threshold,
   output logic [TIME_BITS-1:0] snooze_ticks,
   output logic [TIME_BITS-1:0] detection_ticks
);
   import asoc_pkg::*;

   localparam int ADDR_SHIFT = (DATA_BITS > 32) ? 3 : 2;

   logic [RISK_BITS-1:0] threshold_ff;
   logic [TIME_BITS-1:0] snooze_ff;
   logic [TIME_BITS-1:0] detection_ff;
   reg_index_type        index;
   logic                 write_en;

   assign index    = paddr[ADDR_SHIFT+1:ADDR_SHIFT];
   assign write_en = psel & penable & pwrite;
   assign pready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= RISK_BITS'(RISK_THRESHOLD_RESET);
         snooze_ff    <= '0;
         detection_ff <= '0;
      end else if (write_en) begin
         unique case (index)
            REG_RISK_THRESHOLD:  threshold_ff <= pwdata[RISK_BITS-1:0];
            REG_SNOOZE_TICKS:    snooze_ff    <= pwdata[TIME_BITS-1:0];
            REG_DETECTION_TICKS: detection_ff <= pwdata[TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_RISK_THRESHOLD:  prdata = DATA_BITS'(threshold_ff);
         REG_SNOOZE_TICKS:    prdata = DATA_BITS'(snooze_ff);
         REG_DETECTION_TICKS: prdata = DATA_BITS'(detection_ff);
         default:             prdata = '0;
      endcase
   end

   assign risk_threshold  = threshold_ff;
   assign snooze_ticks    = snooze_ff;
   assign detection_ticks = detection_ff;

endmodule

### test/alert_snooze_outcome_counter_top_tb.sv
`timescale 1ns / 1ps

module alert_snooze_outcome_counter_top_tb;
   import asoc_pkg::*;

   localparam int TW = TIME_BITS_DEFAULT;
   localparam int RW = RISK_BITS_DEFAULT;
   localparam int CW = COUNT_BITS_DEFAULT;
   localparam int N_COUNTERS = 6;
   localparam int HOLD_CYCLES = 80;
   localparam reg_index_type REG_UNUSED = 2'd3;

   typedef enum int {
      CNT_EP_TP, CNT_EP_FN, CNT_EP_FP, CNT_EP_TN, CNT_PR_TP, CNT_PR_FP
   } counter_type;

   typedef struct packed {
      logic [TW-1:0] sample_time;
      logic [RW-1:0] risk;
      logic          has_event;
      logic [TW-1:0] event_tick;
      logic          first_traj;
      logic          last_traj;
      logic          first_run;
   } alert_sample_type;

   typedef struct packed {
      logic                           alert;
      logic                           hit;
      logic [N_COUNTERS-1:0][CW-1:0]  count;
   } alert_outcome_type;

   class outcome_scoreboard;
      logic [RW-1:0]                 threshold;
      logic [TW-1:0]                 snooze_len;
      logic [TW-1:0]                 detect_len;
      logic [TW:0]                   snooze_end;
      logic                          armed;
      logic                          traj_alerted;
      logic                          traj_hit;
      logic [N_COUNTERS-1:0][CW-1:0] tally;
      alert_outcome_type             pending[$];
      int                            errors;

      function new();
         threshold = RW'(RISK_THRESHOLD_RESET);
         snooze_len = '0;
         detect_len = '0;
         snooze_end = '0;
         tally = '0;
         errors = 0;
         clear_trajectory();
      endfunction

      function void clear_trajectory();
         armed = 1'b0;
         traj_alerted = 1'b0;
         traj_hit = 1'b0;
      endfunction

      function void bump(counter_type c);
         if (tally[c] != {CW{1'b1}}) begin
            tally[c] = tally[c] + 1'b1;
         end
      endfunction

      function void write_reg(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_RISK_THRESHOLD: begin
               threshold = value[RW-1:0];
            end
            REG_SNOOZE_TICKS: begin
               snooze_len = value[TW-1:0];
            end
            REG_DETECTION_TICKS: begin
               detect_len = value[TW-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function void note_sample(alert_sample_type s);
         alert_outcome_type want;
         logic [TW:0]       reach;
         if (s.first_run) begin
            tally = '0;
         end
         if (s.first_traj) begin
            clear_trajectory();
         end
         want.alert = 1'b0;
         want.hit = 1'b0;
         if (s.risk > threshold && (!armed || {1'b0, s.sample_time} > snooze_end)) begin
            want.alert = 1'b1;
            armed = 1'b1;
            traj_alerted = 1'b1;
            snooze_end = {1'b0, s.sample_time} + {1'b0, snooze_len};
            reach = {1'b0, s.sample_time} + {1'b0, detect_len};
            want.hit = s.has_event && (s.sample_time < s.event_tick)
                       && (reach >= {1'b0, s.event_tick});
            if (want.hit) begin
               traj_hit = 1'b1;
               bump(CNT_PR_TP);
            end else begin
               bump(CNT_PR_FP);
            end
         end
         if (s.last_traj) begin
            if (s.has_event) begin
               bump(traj_hit ? CNT_EP_TP : CNT_EP_FN);
            end else begin
               bump(traj_alerted ? CNT_EP_FP : CNT_EP_TN);
            end
            clear_trajectory();
         end
         want.count = tally;
         pending.push_back(want);
      endfunction

      function void check_result(alert_outcome_type got);
         alert_outcome_type want;
         counter_type       c;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: result beat with nothing expected (alert %0b)", $time, got.alert);
            return;
         end
         want = pending.pop_front();
         if (got.alert !== want.alert) begin
            errors++;
            $display("%0t: alert expected %0b, got %0b", $time, want.alert, got.alert);
         end
         if (got.hit !== want.hit) begin
            errors++;
            $display("%0t: alert_is_hit expected %0b, got %0b", $time, want.hit, got.hit);
         end
         for (int i = 0; i < N_COUNTERS; i++) begin
            if (got.count[i] !== want.count[i]) begin
               errors++;
               c = counter_type'(i);
               $display("%0t: %s expected %0d, got %0d", $time, c.name(),
                        want.count[i], got.count[i]);
            end
         end
      endfunction
   endclass

   logic          clock;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [TW-1:0] req_sample_time = '0;
   logic [RW-1:0] req_risk = '0;
   logic          req_has_event = 1'b0;
   logic [TW-1:0] req_event_tick = '0;
   logic          req_first_of_trajectory = 1'b0;
   logic          req_last_of_trajectory = 1'b0;
   logic          req_first_of_run = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic          rsp_alert;
   logic          rsp_alert_is_hit;
   logic [CW-1:0] rsp_episode_tp_count;
   logic [CW-1:0] rsp_episode_fn_count;
   logic [CW-1:0] rsp_episode_fp_count;
   logic [CW-1:0] rsp_episode_tn_count;
   logic [CW-1:0] rsp_prediction_tp_count;
   logic [CW-1:0] rsp_prediction_fp_count;
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [3:0]    csr_paddr = '0;
   logic [31:0]   csr_pwdata = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   outcome_scoreboard board = new();
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit hold_rsp_request = 1'b0;

   alert_snooze_outcome_counter_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_time(req_sample_time),
      .req_risk(req_risk),
      .req_has_event(req_has_event),
      .req_event_tick(req_event_tick),
      .req_first_of_trajectory(req_first_of_trajectory),
      .req_last_of_trajectory(req_last_of_trajectory),
      .req_first_of_run(req_first_of_run),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_alert(rsp_alert),
      .rsp_alert_is_hit(rsp_alert_is_hit),
      .rsp_episode_tp_count(rsp_episode_tp_count),
      .rsp_episode_fn_count(rsp_episode_fn_count),
      .rsp_episode_fp_count(rsp_episode_fp_count),
      .rsp_episode_tn_count(rsp_episode_tn_count),
      .rsp_prediction_tp_count(rsp_prediction_tp_count),
      .rsp_prediction_fp_count(rsp_prediction_fp_count),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("alert_snooze_outcome_counter_top test failed");
      $finish;
   end

   // result side: check each beat, random backpressure, one long hold on request
   initial begin
      alert_outcome_type got;
      int                hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready) begin
            got.alert = rsp_alert;
            got.hit = rsp_alert_is_hit;
            got.count[CNT_EP_TP] = rsp_episode_tp_count;
            got.count[CNT_EP_FN] = rsp_episode_fn_count;
            got.count[CNT_EP_FP] = rsp_episode_fp_count;
            got.count[CNT_EP_TN] = rsp_episode_tn_count;
            got.count[CNT_PR_TP] = rsp_prediction_tp_count;
            got.count[CNT_PR_FP] = rsp_prediction_fp_count;
            board.check_result(got);
         end
         if (hold_rsp_request) begin
            hold_left = HOLD_CYCLES;
            hold_rsp_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !rsp_idle_on || ($urandom_range(0, 99) >= 14);
         end
      end
   end

   function automatic alert_sample_type sample_of(logic [TW-1:0] t, logic [RW-1:0] risk,
                                                  logic has_ev, logic [TW-1:0] ev,
                                                  logic first_traj, logic last_traj,
                                                  logic first_run);
      alert_sample_type s;
      s.sample_time = t;
      s.risk = risk;
      s.has_event = has_ev;
      s.event_tick = ev;
      s.first_traj = first_traj;
      s.last_traj = last_traj;
      s.first_run = first_run;
      return s;
   endfunction

   function automatic logic [TW-1:0] later(logic [TW-1:0] t, logic [TW-1:0] d);
      logic [TW:0] sum;
      sum = {1'b0, t} + {1'b0, d};
      return sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
   endfunction

   function automatic logic [RW-1:0] risk_near(logic [RW-1:0] thr);
      int v;
      if ($urandom_range(0, 1) == 0) begin
         return RW'($urandom);
      end
      v = int'(thr) + int'($urandom_range(0, 8)) - 4;
      if (v < 0) begin
         v = 0;
      end
      if (v > (1 << RW) - 1) begin
         v = (1 << RW) - 1;
      end
      return RW'(v);
   endfunction

   function automatic logic [31:0] pick_window();
      case ($urandom_range(0, 3))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2: begin
            return $urandom_range(0, 4096);
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   task automatic send_sample(alert_sample_type s);
      if (req_idle_on && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_time <= s.sample_time;
      req_risk <= s.risk;
      req_has_event <= s.has_event;
      req_event_tick <= s.event_tick;
      req_first_of_trajectory <= s.first_traj;
      req_last_of_trajectory <= s.last_traj;
      req_first_of_run <= s.first_run;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_sample(s);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.write_reg(idx, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(logic [RW-1:0] thr, logic [31:0] snooze, logic [31:0] detect);
      write_reg(REG_RISK_THRESHOLD, {16'($urandom), thr});
      write_reg(REG_SNOOZE_TICKS, snooze);
      write_reg(REG_DETECTION_TICKS, detect);
   endtask

   task automatic run_trajectories(int n_items);
      int               sent;
      int               len;
      int               span;
      logic [TW-1:0]    t;
      logic [TW-1:0]    ev;
      logic             has_ev;
      alert_sample_type s;
      sent = 0;
      if (board.snooze_len > 65536) begin
         span = 65536;
      end else if (board.snooze_len < 16) begin
         span = 16;
      end else begin
         span = int'(board.snooze_len);
      end
      while (sent < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            s = sample_of($urandom, RW'($urandom), 1'($urandom), $urandom,
                          1'($urandom), 1'($urandom), $urandom_range(0, 19) == 0);
            send_sample(s);
            sent++;
         end else begin
            len = $urandom_range(1, 12);
            if ($urandom_range(0, 7) == 0) begin
               t = {TW{1'b1}} - $urandom_range(0, span * 4);
            end else begin
               t = $urandom;
            end
            has_ev = $urandom_range(0, 9) < 6;
            if ($urandom_range(0, 7) == 0) begin
               ev = $urandom;
            end else begin
               ev = later(t, $urandom_range(0, len * span));
            end
            for (int i = 0; i < len; i++) begin
               if (i > 0) begin
                  t = later(t, $urandom_range(0, span));
               end
               s = sample_of(t, risk_near(board.threshold), has_ev, ev,
                             (i == 0) && ($urandom_range(0, 19) != 0),
                             (i == len - 1) && ($urandom_range(0, 19) != 0),
                             (i == 0) && ($urandom_range(0, 29) == 0));
               send_sample(s);
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset config: threshold at half scale, no snooze, empty detection window
      send_sample(sample_of(0, 16'h8000, 0, 0, 1, 0, 1));
      send_sample(sample_of(0, 16'h8001, 0, 0, 0, 0, 0));
      send_sample(sample_of(0, 16'hFFFF, 0, 0, 0, 1, 0));
      settle();

      set_config(16'd1000, 32'd100, 32'd50);
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      send_sample(sample_of(900, 2000, 1, 1050, 1, 0, 0));
      send_sample(sample_of(1000, 2000, 1, 1050, 0, 0, 0));
      send_sample(sample_of(1001, 1000, 1, 1050, 0, 0, 0));
      send_sample(sample_of(1001, 1001, 1, 1050, 0, 0, 0));
      send_sample(sample_of(1101, 16'hFFFF, 1, 1050, 0, 1, 0));
      send_sample(sample_of(1949, 5000, 1, 2000, 1, 0, 0));
      send_sample(sample_of(2050, 5000, 1, 2000, 0, 1, 0));
      send_sample(sample_of(2950, 4000, 1, 3000, 1, 0, 0));
      send_sample(sample_of(3051, 4000, 1, 3000, 0, 1, 0));
      send_sample(sample_of(5000, 0, 0, 0, 1, 1, 0));
      // next trajectory without its start flag
      send_sample(sample_of(10, 2000, 0, 0, 0, 0, 0));
      send_sample(sample_of(20, 2000, 0, 0, 0, 1, 0));
      send_sample(sample_of(0, 0, 0, 0, 1, 1, 1));
      // scoring takes the event flag of the last beat
      send_sample(sample_of(100, 2000, 0, 0, 1, 0, 0));
      send_sample(sample_of(500, 0, 1, 600, 0, 1, 0));
      settle();

      set_config(16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_sample(sample_of('1, 1, 1, '1, 1, 0, 0));
      send_sample(sample_of('1, 16'hFFFF, 1, '1, 0, 1, 0));
      send_sample(sample_of(0, 1, 1, '1, 1, 1, 0));
      send_sample(sample_of(5, 0, 0, '1, 1, 1, 0));
      settle();

      set_config(16'hFFFF, 32'd0, 32'd0);
      send_sample(sample_of(7, 16'hFFFF, 1, 8, 1, 1, 0));
      settle();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin
               set_config(RW'($urandom), $urandom_range(0, 200), $urandom_range(0, 400));
            end
            1: begin
               set_config(16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            end
            2: begin
               set_config(RW'($urandom), 32'd0, 32'd0);
            end
            default: begin
               set_config(RW'($urandom), pick_window(), pick_window());
            end
         endcase
         req_idle_on = (p != 3);
         rsp_idle_on = (p != 3);
         if (p == 3 || p == 6) begin
            hold_rsp_request = 1'b1;
         end
         run_trajectories(237);
         settle();
      end

      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("alert_snooze_outcome_counter_top test passed");
      end else begin
         $display("alert_snooze_outcome_counter_top test failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/asoc_pkg.sv
rtl/asoc_csr.sv
rtl/alert_snooze_outcome_counter_top.sv
test/alert_snooze_outcome_counter_top_tb.sv
